>>> src/lotp_pkg.sv
// Lottery thread picker: shared constants, action codes and struct types.
// No dependencies; imported by every module of the block.
package lotp_pkg;

   localparam int SLOT_COUNT      = 8;
   localparam int SLOT_W          = 3;
   localparam int MAX_THREADS_DEF = 8;
   localparam int TICK_W          = 16;
   localparam int CUR_W           = 4;
   localparam int ACTION_W        = 2;
   localparam int RND_W           = 31;
   localparam int CNT_W           = 4;
   localparam int SUM_W           = 19;          // eight 16-bit counts
   localparam int ALU_W           = SUM_W + 1;   // remainder shifted by one bit
   localparam int STEP_W          = 5;           // counts the RND_W division steps
   localparam int ADDR_W          = 5;
   localparam int DATA_W          = 32;

   localparam logic [CUR_W-1:0] NO_THREAD = CUR_W'(SLOT_COUNT);

   localparam logic [ACTION_W-1:0] ACT_DRAW    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FINISH  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

   typedef logic [SLOT_COUNT-1:0][TICK_W-1:0] ticket_array_type;

   typedef struct packed {
      logic             sub;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] res;
      logic             borrow;
   } alu_rsp_type;

   typedef struct packed {
      logic [SLOT_W-1:0] chosen_thread;
      logic              none_left;
      logic [CNT_W-1:0]  remaining_count;
   } result_type;

endpackage

>>> src/lotp_csr.sv
// Lottery thread picker: ticket count register file behind the APB-style port.
// Depends on lotp_pkg.
module lotp_csr
   import lotp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output ticket_array_type  tickets
);

   ticket_array_type  tick_ff;
   ticket_array_type  tick_in;
   logic [SLOT_W-1:0] reg_idx;

   assign reg_idx = paddr[ADDR_W-1:2];

   always_comb begin
      tick_in = tick_ff;
      if (psel && penable && pwrite) begin
         tick_in[reg_idx] = pwdata[TICK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else begin
         tick_ff <= tick_in;
      end
   end

   assign prdata  = {{(DATA_W-TICK_W){1'b0}}, tick_ff[reg_idx]};
   assign pready  = 1'b1;
   assign tickets = tick_ff;

endmodule

>>> src/lotp_alu.sv
// Lottery thread picker: shared add/subtract unit used by every phase.
// Depends on lotp_pkg.
module lotp_alu
   import lotp_pkg::*;
(
   input  alu_req_type op,
   output alu_rsp_type rsp
);

   logic [ALU_W:0] full;

   // subtract as a + ~b + 1; carry out low means borrow
   assign full       = {1'b0, op.a} + {1'b0, (op.sub ? ~op.b : op.b)} + {{ALU_W{1'b0}}, op.sub};
   assign rsp.res    = full[ALU_W-1:0];
   assign rsp.borrow = op.sub & ~full[ALU_W];

endmodule

>>> src/lotp_seq.sv
// Lottery thread picker: sequencer for sum, restoring modulo and ticket walk.
// Holds finished flags and current thread. Depends on lotp_pkg, lotp_alu.
module lotp_seq
   import lotp_pkg::*;
#(
   parameter int MAX_THREADS = MAX_THREADS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [RND_W-1:0]    req_random_value,
   input  ticket_array_type    tickets,
   input  logic                slot_free,
   output logic                res_load,
   output result_type          res
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SUM    = 3'd1;
   localparam logic [2:0] ST_MOD    = 3'd2;
   localparam logic [2:0] ST_WALK   = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   localparam logic [SLOT_W-1:0] LAST_IDX  = SLOT_W'(MAX_THREADS - 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RND_W - 1);

   logic [2:0]            state_ff, state_in;
   logic [SLOT_COUNT-1:0] fin_ff, fin_in;
   logic [CUR_W-1:0]      cur_ff, cur_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [SUM_W-1:0]      rem_ff, rem_in;
   logic [RND_W-1:0]      rnd_ff, rnd_in;

   logic [SLOT_COUNT-1:0] elig;
   logic [SLOT_COUNT-1:0] cand;
   logic                  cur_elig;
   logic [CNT_W-1:0]      count;
   alu_req_type           alu_op;
   alu_rsp_type           alu_rsp;

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         elig[i] = (i < MAX_THREADS) && (tickets[i] != '0) && !fin_ff[i];
         cand[i] = elig[i] && (cur_ff != CUR_W'(i));
      end
   end

   assign cur_elig = (cur_ff < NO_THREAD) && elig[cur_ff[SLOT_W-1:0]];
   assign count    = CNT_W'($countones(elig));

   always_comb begin
      alu_op = '0;
      unique case (state_ff)
         ST_SUM: begin
            alu_op.a = ALU_W'(sum_ff);
            alu_op.b = cand[idx_ff] ? ALU_W'(tickets[idx_ff]) : '0;
         end
         ST_MOD: begin
            alu_op.sub = 1'b1;
            alu_op.a   = {rem_ff, rnd_ff[RND_W-1]};
            alu_op.b   = ALU_W'(sum_ff);
         end
         ST_WALK: begin
            alu_op.sub = 1'b1;
            alu_op.a   = ALU_W'(rem_ff);
            alu_op.b   = ALU_W'(tickets[idx_ff]);
         end
         default: begin
            alu_op = '0;
         end
      endcase
   end

   lotp_alu u_alu (
      .op  (alu_op),
      .rsp (alu_rsp)
   );

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      step_in  = step_ff;
      sum_in   = sum_ff;
      rem_in   = rem_ff;
      rnd_in   = rnd_ff;
      res_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rnd_in = req_random_value;
               idx_in = '0;
               sum_in = '0;
               case (req_action)
                  ACT_DRAW: begin
                     state_in = ST_SUM;
                  end
                  ACT_FINISH: begin
                     if (cur_ff < NO_THREAD) begin
                        fin_in[cur_ff[SLOT_W-1:0]] = 1'b1;
                     end
                     state_in = ST_SUM;
                  end
                  ACT_RESTART: begin
                     fin_in   = '0;
                     cur_in   = NO_THREAD;
                     state_in = ST_RESULT;
                  end
                  default: begin
                     state_in = ST_RESULT;
                  end
               endcase
            end
         end
         ST_SUM: begin
            sum_in = alu_rsp.res[SUM_W-1:0];
            if (idx_ff == LAST_IDX) begin
               rem_in  = '0;
               step_in = '0;
               if (alu_rsp.res == '0) begin
                  if (!cur_elig) begin
                     cur_in = NO_THREAD;
                  end
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_MOD;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_MOD: begin
            rem_in = alu_rsp.borrow ? alu_op.a[SUM_W-1:0] : alu_rsp.res[SUM_W-1:0];
            rnd_in = rnd_ff << 1;
            if (step_ff == LAST_STEP) begin
               idx_in   = '0;
               state_in = ST_WALK;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_WALK: begin
            if (cand[idx_ff] && alu_rsp.borrow) begin
               cur_in   = {1'b0, idx_ff};
               state_in = ST_RESULT;
            end else begin
               if (cand[idx_ff]) begin
                  rem_in = alu_rsp.res[SUM_W-1:0];
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_RESULT;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_RESULT: begin
            if (slot_free) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff   <= '0;
         cur_ff   <= NO_THREAD;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         cur_ff   <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      step_ff <= step_in;
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      rnd_ff  <= rnd_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign res.chosen_thread   = (cur_ff < NO_THREAD) ? cur_ff[SLOT_W-1:0] : '0;
   assign res.none_left       = (count == '0);
   assign res.remaining_count = count;

endmodule

>>> src/lottery_thread_picker_core.sv
// Lottery thread picker, top level: register file, sequencer, result register.
// Depends on lotp_pkg, lotp_csr, lotp_seq (which uses lotp_alu).
//
//  channel  direction  handshake              beat contents
//  req      in         req_valid / req_stall  action, random_value
//  rsp      out        rsp_valid / rsp_stall  chosen_thread, none_left, remaining_count
//  csr      in/out     psel, penable, pready  tickets_thread0..7 at byte address 4*i
//
// A draw or finish beat runs the sum over MAX_THREADS slots, the restoring modulo
//   one random bit at a time, the ticket walk and then the result state; the sum,
//   modulo and walk share the single add/subtract unit, one step a cycle.
// Restart and unknown actions go straight to the result state; a draw with no other
//   tickets skips the modulo and walk.
// req_stall is high from acceptance until the result is loaded into the output
//   register; the next beat is taken while that result still waits on rsp_stall.
// Synchronous reset clears tickets and finished flags, and leaves no current thread.
module lottery_thread_picker_core
   import lotp_pkg::*;
#(
   parameter int MAX_THREADS = MAX_THREADS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [RND_W-1:0]    req_random_value,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SLOT_W-1:0]   rsp_chosen_thread,
   output logic                rsp_none_left,
   output logic [CNT_W-1:0]    rsp_remaining_count,
   // configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   ticket_array_type tickets;
   logic             slot_free;
   logic             res_load;
   result_type       res;

   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;

   // ticket counts; slots at or above MAX_THREADS are stored but never eligible
   lotp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .tickets (tickets)
   );

   // output slot frees up when empty or when its beat is taken this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   lotp_seq #(
      .MAX_THREADS (MAX_THREADS)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_random_value (req_random_value),
      .tickets          (tickets),
      .slot_free        (slot_free),
      .res_load         (res_load),
      .res              (res)
   );

   // result register parts the sequencer from the consumer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_chosen_thread   = rsp_ff.chosen_thread;
   assign rsp_none_left       = rsp_ff.none_left;
   assign rsp_remaining_count = rsp_ff.remaining_count;

endmodule

>>> src/lotp_checker.sv
// Lottery thread picker: port-level checker and its bind to the top level.
// Depends on lotp_pkg and lottery_thread_picker_core.
module lotp_checker
   import lotp_pkg::*;
#(
   parameter int MAX_THREADS = MAX_THREADS_DEF
)
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [SLOT_W-1:0]   rsp_chosen_thread,
   input logic                rsp_none_left,
   input logic [CNT_W-1:0]    rsp_remaining_count
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_chosen_thread)
         && $stable(rsp_none_left) && $stable(rsp_remaining_count))
      else $error("stalled result beat changed");

   // one beat at a time: busy straight after an accepted request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous beat in work");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_none_left == (rsp_remaining_count == '0)))
      else $error("none_left disagrees with remaining_count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_remaining_count <= MAX_THREADS)
         && (rsp_chosen_thread < MAX_THREADS))
      else $error("result names a slot beyond MAX_THREADS");

endmodule

bind lottery_thread_picker_core lotp_checker #(
   .MAX_THREADS (MAX_THREADS)
) u_lotp_checker (.*);
